// File: rtl/core/mvtc_pkg.sv
// Shared types and constants for the markup visible text counter.
// No dependencies; imported by mvtc_tag_tracker and markup_visible_text_counter.
`default_nettype none

package mvtc_pkg;

  localparam int unsigned UNIT_W = 31;
  localparam logic [UNIT_W-1:0] UNIT_MAX = 31'h7FFF_FFFF;

  localparam logic [7:0] CH_LT    = 8'h3C;  // '<'
  localparam logic [7:0] CH_GT    = 8'h3E;  // '>'
  localparam logic [7:0] CH_SLASH = 8'h2F;  // '/'

  localparam logic [1:0] CONT_TAG  = 2'b10;  // UTF-8 continuation byte top bits
  localparam int unsigned SCRIPT_LEN = 6;
  localparam int unsigned STYLE_LEN  = 5;

  // Status from the tag tracker for the byte in the working stage
  typedef struct packed {
    logic visible;  // byte counts as a text unit
    logic in_tag;   // tracker was inside a tag before this byte
    logic in_raw;   // tracker was inside script or style before this byte
  } mvtc_status_t;

  function automatic logic [7:0] script_char(input logic [2:0] pos);
    logic [7:0] c;
    unique case (pos)
      3'd0:    c = 8'h73;  // s
      3'd1:    c = 8'h63;  // c
      3'd2:    c = 8'h72;  // r
      3'd3:    c = 8'h69;  // i
      3'd4:    c = 8'h70;  // p
      3'd5:    c = 8'h74;  // t
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] style_char(input logic [2:0] pos);
    logic [7:0] c;
    unique case (pos)
      3'd0:    c = 8'h73;  // s
      3'd1:    c = 8'h74;  // t
      3'd2:    c = 8'h79;  // y
      3'd3:    c = 8'h6C;  // l
      3'd4:    c = 8'h65;  // e
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/mvtc_tag_tracker.sv
// Tag, closing-slash and script/style mode tracking for one byte per cycle while step is high.
// Depends on mvtc_pkg.
`default_nettype none

module mvtc_tag_tracker
  import mvtc_pkg::*;
#(
  parameter int unsigned TAG_LETTER_CAP = 15
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic       last,
  input  wire logic [7:0] data_byte,
  output mvtc_status_t    status
);

  localparam int unsigned LW = $clog2(TAG_LETTER_CAP + 1);

  logic          in_tag_r, in_tag_nxt;
  logic          closing_r, closing_nxt;
  logic [LW-1:0] letters_r, letters_nxt;
  logic          pm_script_r, pm_script_nxt;
  logic          pm_style_r, pm_style_nxt;
  logic          script_r, script_nxt;
  logic          style_r, style_nxt;

  logic       is_upper, is_lower;
  logic [7:0] lc;

  assign is_upper = (data_byte >= 8'h41) && (data_byte <= 8'h5A);
  assign is_lower = (data_byte >= 8'h61) && (data_byte <= 8'h7A);
  assign lc       = data_byte | 8'h20;

  always_comb begin
    in_tag_nxt    = in_tag_r;
    closing_nxt   = closing_r;
    letters_nxt   = letters_r;
    pm_script_nxt = pm_script_r;
    pm_style_nxt  = pm_style_r;
    script_nxt    = script_r;
    style_nxt     = style_r;
    if (step) begin
      if (in_tag_r) begin
        if (data_byte == CH_GT) begin
          if (letters_r == LW'(SCRIPT_LEN) && pm_script_r) script_nxt = !closing_r;
          if (letters_r == LW'(STYLE_LEN) && pm_style_r)   style_nxt  = !closing_r;
          in_tag_nxt = 1'b0;
        end else if (letters_r == '0 && data_byte == CH_SLASH) begin
          closing_nxt = 1'b1;
        end else if (letters_r < LW'(TAG_LETTER_CAP) && (is_upper || is_lower)) begin
          if (!(letters_r < LW'(SCRIPT_LEN) && lc == script_char(letters_r[2:0])))
            pm_script_nxt = 1'b0;
          if (!(letters_r < LW'(STYLE_LEN) && lc == style_char(letters_r[2:0])))
            pm_style_nxt = 1'b0;
          letters_nxt = letters_r + LW'(1);
        end
      end else if (data_byte == CH_LT) begin
        in_tag_nxt    = 1'b1;
        closing_nxt   = 1'b0;
        letters_nxt   = '0;
        pm_script_nxt = 1'b1;
        pm_style_nxt  = 1'b1;
      end
      // end of document: back to the reset state after this byte
      if (last) begin
        in_tag_nxt    = 1'b0;
        closing_nxt   = 1'b0;
        letters_nxt   = '0;
        pm_script_nxt = 1'b1;
        pm_style_nxt  = 1'b1;
        script_nxt    = 1'b0;
        style_nxt     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_tag_r    <= 1'b0;
      closing_r   <= 1'b0;
      letters_r   <= '0;
      pm_script_r <= 1'b1;
      pm_style_r  <= 1'b1;
      script_r    <= 1'b0;
      style_r     <= 1'b0;
    end else begin
      in_tag_r    <= in_tag_nxt;
      closing_r   <= closing_nxt;
      letters_r   <= letters_nxt;
      pm_script_r <= pm_script_nxt;
      pm_style_r  <= pm_style_nxt;
      script_r    <= script_nxt;
      style_r     <= style_nxt;
    end
  end

  always_comb begin
    status.in_tag  = in_tag_r;
    status.in_raw  = script_r || style_r;
    status.visible = !in_tag_r && (data_byte != CH_LT) && !script_r && !style_r &&
                     (data_byte[7:6] != CONT_TAG);
  end

`ifndef NO_ASSERTIONS
  a_letters_capped: assert property (@(posedge clk) disable iff (!rst_n)
    letters_r <= LW'(TAG_LETTER_CAP))
    else $error("tag letter count above cap");

  a_open_tag: assert property (@(posedge clk) disable iff (!rst_n)
    step && !last && !in_tag_r && data_byte == CH_LT
    |=> in_tag_r && !closing_r && letters_r == '0)
    else $error("tag not opened on '<'");

  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    step && last |=> !in_tag_r && !script_r && !style_r && letters_r == '0)
    else $error("tracker not reset after last byte");
`endif

endmodule

`default_nettype wire

// File: rtl/core/markup_visible_text_counter.sv
// Top level of the markup visible text counter: input stage, unit counter, result register.
// Depends on mvtc_pkg and mvtc_tag_tracker.
//
//   channel | direction | ports                              | transfer
//   in      | input     | in_data_byte, in_last_byte         | in_valid & in_ready
//   out     | output    | out_text_units                     | out_valid & out_ready
//
// One byte per cycle sustained, except while a last byte waits; a byte is registered in the
// input stage, then its tag/mode update and the saturating count increment happen as it leaves it.
// A result is registered when the last byte leaves the input stage and sits in the output register
// while further bytes of the next document keep flowing in.
// Only a second last byte waits, and then only while the previous result is not taken.
// Synchronous active-low reset clears all control state and the count.
`default_nettype none

module markup_visible_text_counter
  import mvtc_pkg::*;
#(
  parameter int unsigned TAG_LETTER_CAP = 15
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        in_data_byte,
  input  wire logic              in_last_byte,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [UNIT_W-1:0]      out_text_units
);

  logic              stage_v_r;
  logic [7:0]        stage_byte_r;
  logic              stage_last_r;
  logic [UNIT_W-1:0] count_r, count_nxt;
  logic              out_valid_r;
  logic [UNIT_W-1:0] out_units_r;
  logic              advance;
  logic [UNIT_W-1:0] count_upd;
  mvtc_status_t      status;

  assign advance  = stage_v_r && (!stage_last_r || !out_valid_r || out_ready);
  assign in_ready = !stage_v_r || advance;

  mvtc_tag_tracker #(
    .TAG_LETTER_CAP(TAG_LETTER_CAP)
  ) u_tags (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .last      (stage_last_r),
    .data_byte (stage_byte_r),
    .status    (status)
  );

  assign count_upd = (status.visible && count_r != UNIT_MAX) ? count_r + UNIT_W'(1) : count_r;

  always_comb begin
    count_nxt = count_r;
    if (advance) count_nxt = stage_last_r ? '0 : count_upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r   <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (in_ready) stage_v_r <= in_valid;
      if (advance && stage_last_r) out_valid_r <= 1'b1;
      else if (out_ready)          out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_byte_r <= in_data_byte;
      stage_last_r <= in_last_byte;
    end
    if (advance && stage_last_r) out_units_r <= count_upd;
  end

  assign out_valid      = out_valid_r;
  assign out_text_units = out_units_r;

`ifndef NO_ASSERTIONS
  a_visible_outside_markup: assert property (@(posedge clk) disable iff (!rst_n)
    stage_v_r && status.visible |-> !status.in_tag && !status.in_raw)
    else $error("counted a byte inside a tag or script/style");

  a_count_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    advance && stage_last_r |=> count_r == '0)
    else $error("count not cleared after last byte");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !stage_last_r && status.visible && count_r != UNIT_MAX
    |=> count_r == $past(count_r) + UNIT_W'(1))
    else $error("count did not advance on a visible byte");

  a_result_not_overwritten: assert property (@(posedge clk) disable iff (!rst_n)
    stage_v_r && stage_last_r && out_valid_r && !out_ready |-> !advance)
    else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire
